// ===== src/key_triggered_stepper_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Key-triggered stepper sequencer: assertion macros
// Shared concurrent-check macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_TRIGGERED_STEPPER_SEQUENCER_UNIT_ASSERT_SVH
`define KEY_TRIGGERED_STEPPER_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define KTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// Key-triggered stepper sequencer package
// Types, register indexes, reset values and coil decode shared by the block.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_SCAN_PERIOD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PHASE_TIME   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_CYCLES  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAUSE_TIME   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_SCANS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_SCANS = 3'd5;

  localparam logic [7:0]  RST_SCAN_PERIOD  = 8'd10;
  localparam logic [9:0]  RST_PHASE_TIME   = 10'd20;
  localparam logic [7:0]  RST_STEP_CYCLES  = 8'd240;
  localparam logic [15:0] RST_PAUSE_TIME   = 16'd8000;
  localparam logic [6:0]  RST_HOLD_SCANS   = 7'd100;
  localparam logic [6:0]  RST_REPEAT_SCANS = 7'd10;

  localparam logic [1:0] KP_IDLE    = 2'd0;
  localparam logic [1:0] KP_CONFIRM = 2'd1;
  localparam logic [1:0] KP_HELD    = 2'd2;
  localparam logic [1:0] KP_REPEAT  = 2'd3;

  typedef enum logic [3:0] {
    KS_IDLE    = 4'b0001,
    KS_CONFIRM = 4'b0010,
    KS_HELD    = 4'b0100,
    KS_REPEAT  = 4'b1000
  } scan_state_t;

  typedef enum logic [3:0] {
    MM_IDLE  = 4'b0001,
    MM_FWD   = 4'b0010,
    MM_PAUSE = 4'b0100,
    MM_REV   = 4'b1000
  } motor_mode_t;

  typedef struct packed {
    motor_mode_t mode;
    logic [1:0]  phase;
    logic [7:0]  cycles;
    logic [15:0] ms;
  } motor_st_t;

  function automatic logic [3:0] coil_decode(motor_mode_t mode, logic [1:0] phase);
    logic [3:0] coil;
    unique case (mode)
      MM_FWD:   coil = 4'b0001 << phase;
      MM_REV:   coil = 4'b1000 >> phase;
      MM_PAUSE: coil = 4'b1000;
      default:  coil = 4'b0000;
    endcase
    return coil;
  endfunction

  function automatic logic [1:0] phase_code(scan_state_t st);
    logic [1:0] code;
    unique case (st)
      KS_CONFIRM: code = KP_CONFIRM;
      KS_HELD:    code = KP_HELD;
      KS_REPEAT:  code = KP_REPEAT;
      default:    code = KP_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== src/key_triggered_stepper_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// Key-triggered stepper sequencer
// Debounced key scan that launches a forward / pause / reverse stepper run.
// ----------------------------------------------------------------------------
// channel  dir  item                     fields (lowest bit first)
// in_      in   one 1 ms tick            key_level
// out_     out  one result per tick      coil_drive, motor_busy, key_phase
// cfg_     in   register write           index 0..5, data
//
// One item per clock while out_tready holds; the next state and the result are formed
// combinationally and held in the output register. A new item is taken while the output
// register is empty or being drained. Synchronous active-low reset restores
// the register defaults, idle scan machine and coils off.
// ----------------------------------------------------------------------------
`include "key_triggered_stepper_sequencer_unit_assert.svh"

module key_triggered_stepper_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [0] key_level, [7:1] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [3:0] coil_drive, [4] motor_busy, [6:5] key_phase
  output logic [7:0]                    out_tdata,
  input  logic                          cfg_we,
  input  logic [kts_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [kts_pkg::CfgDataW-1:0]  cfg_wdata
);

  logic [7:0]  scan_period_r;
  logic [9:0]  phase_time_r;
  logic [7:0]  step_cycles_r;
  logic [15:0] pause_time_r;
  logic [6:0]  hold_scans_r;
  logic [6:0]  repeat_scans_r;

  kts_pkg::scan_state_t scan_state_r, scan_state_nxt;
  logic [6:0]           hold_count_r, hold_count_nxt;
  logic [7:0]           scan_div_r, scan_div_nxt;
  kts_pkg::motor_st_t   motor_r, motor_nxt;
  logic                 start;

  logic       out_valid_r;
  logic [7:0] out_data_r;

  logic       in_acc;
  logic       pressed;
  logic       running;
  logic [7:0] div_inc;
  logic [6:0] hold_inc;

  logic        coil_ok;
  logic        run_acc;
  logic [11:0] scan_bits;
  logic [33:0] state_bits;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pressed  = !in_tdata[0];
  assign running  = motor_r.mode != kts_pkg::MM_IDLE;
  assign div_inc  = 8'(scan_div_r + 8'd1);
  assign hold_inc = 7'(hold_count_r + 7'd1);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_period_r  <= kts_pkg::RST_SCAN_PERIOD;
      phase_time_r   <= kts_pkg::RST_PHASE_TIME;
      step_cycles_r  <= kts_pkg::RST_STEP_CYCLES;
      pause_time_r   <= kts_pkg::RST_PAUSE_TIME;
      hold_scans_r   <= kts_pkg::RST_HOLD_SCANS;
      repeat_scans_r <= kts_pkg::RST_REPEAT_SCANS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kts_pkg::CFG_SCAN_PERIOD:  scan_period_r  <= cfg_wdata[7:0];
        kts_pkg::CFG_PHASE_TIME:   phase_time_r   <= cfg_wdata[9:0];
        kts_pkg::CFG_STEP_CYCLES:  step_cycles_r  <= cfg_wdata[7:0];
        kts_pkg::CFG_PAUSE_TIME:   pause_time_r   <= cfg_wdata;
        kts_pkg::CFG_HOLD_SCANS:   hold_scans_r   <= cfg_wdata[6:0];
        kts_pkg::CFG_REPEAT_SCANS: repeat_scans_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // key scan
  always_comb begin
    scan_state_nxt = scan_state_r;
    hold_count_nxt = hold_count_r;
    scan_div_nxt   = scan_div_r;
    start          = 1'b0;
    if (!running) begin
      if (div_inc >= scan_period_r) begin
        scan_div_nxt = 8'd0;
        unique case (scan_state_r)
          kts_pkg::KS_IDLE: begin
            scan_state_nxt = pressed ? kts_pkg::KS_CONFIRM : kts_pkg::KS_IDLE;
          end
          kts_pkg::KS_CONFIRM: begin
            if (pressed) begin
              hold_count_nxt = 7'd0;
              scan_state_nxt = kts_pkg::KS_HELD;
            end else begin
              scan_state_nxt = kts_pkg::KS_IDLE;
            end
          end
          kts_pkg::KS_HELD: begin
            hold_count_nxt = hold_inc;
            if (!pressed) begin
              scan_state_nxt = kts_pkg::KS_IDLE;
              start          = 1'b1;
            end else if (hold_inc >= hold_scans_r) begin
              hold_count_nxt = 7'd0;
              scan_state_nxt = kts_pkg::KS_REPEAT;
            end
          end
          kts_pkg::KS_REPEAT: begin
            hold_count_nxt = hold_inc;
            if (hold_inc >= repeat_scans_r) begin
              hold_count_nxt = 7'd0;
            end else if (!pressed) begin
              scan_state_nxt = kts_pkg::KS_IDLE;
            end
          end
          default: scan_state_nxt = scan_state_r;
        endcase
      end else begin
        scan_div_nxt = div_inc;
      end
    end
  end

  kts_motor u_motor (
    .cur         (motor_r),
    .start       (start),
    .phase_time  (phase_time_r),
    .step_cycles (step_cycles_r),
    .pause_time  (pause_time_r),
    .nxt         (motor_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_state_r <= kts_pkg::KS_IDLE;
      hold_count_r <= 7'd0;
      scan_div_r   <= 8'd0;
      motor_r      <= '{mode: kts_pkg::MM_IDLE, phase: 2'd0, cycles: 8'd0, ms: 16'd0};
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        scan_state_r <= scan_state_nxt;
        hold_count_r <= hold_count_nxt;
        scan_div_r   <= scan_div_nxt;
        motor_r      <= motor_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {1'b0,
                     kts_pkg::phase_code(scan_state_nxt),
                     motor_nxt.mode != kts_pkg::MM_IDLE,
                     kts_pkg::coil_decode(motor_nxt.mode, motor_nxt.phase)};
    end
  end

  // busy means exactly one coil, idle means none
  assign coil_ok    = out_data_r[4] ? $onehot(out_data_r[3:0]) : (out_data_r[3:0] == 4'd0);
  assign run_acc    = in_acc && running;
  assign scan_bits  = {scan_state_r, scan_div_r};
  assign state_bits = {motor_r, scan_state_r};

  `KTS_ASSERT_IMP(a_coil_drive, out_valid_r, coil_ok, "coil drive disagrees with busy flag")
  `KTS_ASSERT_NXT(a_scan_frozen, run_acc, $stable(scan_bits), "key scan moved while running")
  `KTS_ASSERT_NXT(a_state_hold, !in_acc, $stable(state_bits), "state changed without an item")

endmodule

// ===== src/kts_motor.sv =====
// ----------------------------------------------------------------------------
// Stepper motor sequencer next-state logic
// One millisecond tick of the forward / pause / reverse wave-drive sequence.
// ----------------------------------------------------------------------------
module kts_motor (
  input  kts_pkg::motor_st_t cur,
  input  logic               start,
  input  logic [9:0]         phase_time,
  input  logic [7:0]         step_cycles,
  input  logic [15:0]        pause_time,
  output kts_pkg::motor_st_t nxt
);

  logic [15:0] ms_inc;
  logic [1:0]  phase_inc;
  logic [7:0]  cycles_inc;

  assign ms_inc     = 16'(cur.ms + 16'd1);
  assign phase_inc  = 2'(cur.phase + 2'd1);
  assign cycles_inc = 8'(cur.cycles + 8'd1);

  always_comb begin
    nxt = cur;
    if (start) begin
      nxt.mode   = kts_pkg::MM_FWD;
      nxt.phase  = 2'd0;
      nxt.cycles = 8'd0;
      nxt.ms     = 16'd0;
    end else begin
      unique case (cur.mode)
        kts_pkg::MM_PAUSE: begin
          if (ms_inc >= pause_time) begin
            nxt.mode   = kts_pkg::MM_REV;
            nxt.phase  = 2'd0;
            nxt.cycles = 8'd0;
            nxt.ms     = 16'd0;
          end else begin
            nxt.ms = ms_inc;
          end
        end
        kts_pkg::MM_FWD, kts_pkg::MM_REV: begin
          if (ms_inc < {6'd0, phase_time}) begin
            nxt.ms = ms_inc;
          end else begin
            nxt.ms    = 16'd0;
            nxt.phase = phase_inc;
            if (phase_inc == 2'd0) begin
              if (cycles_inc >= step_cycles) begin
                nxt.cycles = 8'd0;
                if (cur.mode == kts_pkg::MM_FWD) begin
                  nxt.mode = (pause_time == 16'd0) ? kts_pkg::MM_REV : kts_pkg::MM_PAUSE;
                end else begin
                  nxt.mode = kts_pkg::MM_IDLE;
                end
              end else begin
                nxt.cycles = cycles_inc;
              end
            end
          end
        end
        default: nxt = cur;
      endcase
    end
  end

endmodule
